[hdl/tte_pkg.sv]
// Shared types, constants and lookup functions of the timestamp parser.
package tte_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [1:0] MODE_ISO_T     = 2'd0;
   localparam logic [1:0] MODE_ISO_SPACE = 2'd1;
   localparam logic [1:0] MODE_SYSLOG    = 2'd2;
   localparam logic [1:0] MODE_BAD       = 2'd3;

   localparam logic [1:0] CSR_FORMAT_MODE   = 2'd0;
   localparam logic [1:0] CSR_ASSUMED_YEAR  = 2'd1;
   localparam logic [1:0] CSR_ASSUMED_MONTH = 2'd2;

   typedef enum logic [3:0] {
      PH_DATE      = 4'd0,
      PH_SYS_PAD   = 4'd1,
      PH_SYS_FIRST = 4'd2,
      PH_SYS_DAY1  = 4'd3,
      PH_SYS_DAY2  = 4'd4,
      PH_TIME0     = 4'd5,
      PH_TIME1     = 4'd6,
      PH_TIME2     = 4'd7,
      PH_TIME3     = 4'd8,
      PH_TIME4     = 4'd9,
      PH_TIME5     = 4'd10,
      PH_TIME6     = 4'd11,
      PH_TIME7     = 4'd12,
      PH_AFTER_SEC = 4'd13,
      PH_FRACTION  = 4'd14,
      PH_AFTER_Z   = 4'd15
   } phase_type;

   typedef enum logic [1:0] {
      BK_IDLE = 2'd0,
      BK_RUN  = 2'd1,
      BK_DONE = 2'd2
   } back_state_type;

   // One parsed timestamp handed from the byte parser to the converter.
   typedef struct packed {
      logic        ok;
      logic [13:0] year;
      logic [3:0]  month;
      logic [6:0]  day;
      logic [16:0] hms;
      logic [19:0] frac;
      logic [2:0]  fdig;
   } rec_type;

   function automatic logic [3:0] month_of(input logic [7:0] c0, input logic [7:0] c1,
                                           input logic [7:0] c2);
      logic [23:0] s;
      s = {c0, c1, c2};
      case (s)
         "Jan":   month_of = 4'd1;
         "Feb":   month_of = 4'd2;
         "Mar":   month_of = 4'd3;
         "Apr":   month_of = 4'd4;
         "May":   month_of = 4'd5;
         "Jun":   month_of = 4'd6;
         "Jul":   month_of = 4'd7;
         "Aug":   month_of = 4'd8;
         "Sep":   month_of = 4'd9;
         "Oct":   month_of = 4'd10;
         "Nov":   month_of = 4'd11;
         "Dec":   month_of = 4'd12;
         default: month_of = 4'd0;
      endcase
   endfunction

   function automatic logic [4:0] month_days(input logic [3:0] m);
      case (m)
         4'd2:    month_days = 5'd28;
         4'd4:    month_days = 5'd30;
         4'd6:    month_days = 5'd30;
         4'd9:    month_days = 5'd30;
         4'd11:   month_days = 5'd30;
         default: month_days = 5'd31;
      endcase
   endfunction

   // Day of a March-based year on which month m starts.
   function automatic logic [8:0] doy_base(input logic [3:0] m);
      case (m)
         4'd3:    doy_base = 9'd0;
         4'd4:    doy_base = 9'd31;
         4'd5:    doy_base = 9'd61;
         4'd6:    doy_base = 9'd92;
         4'd7:    doy_base = 9'd122;
         4'd8:    doy_base = 9'd153;
         4'd9:    doy_base = 9'd184;
         4'd10:   doy_base = 9'd214;
         4'd11:   doy_base = 9'd245;
         4'd12:   doy_base = 9'd275;
         4'd1:    doy_base = 9'd306;
         4'd2:    doy_base = 9'd337;
         default: doy_base = 9'd0;
      endcase
   endfunction

   function automatic logic [16:0] frac_scale(input logic [2:0] k);
      case (k)
         3'd1:    frac_scale = 17'd100000;
         3'd2:    frac_scale = 17'd10000;
         3'd3:    frac_scale = 17'd1000;
         3'd4:    frac_scale = 17'd100;
         3'd5:    frac_scale = 17'd10;
         default: frac_scale = 17'd1;
      endcase
   endfunction

endpackage

[hdl/tte_front.sv]
// Byte parser: checks the layout byte by byte and emits one record per text.
module tte_front (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       format_mode,
   input  logic [13:0]      assumed_year,
   input  logic [3:0]       assumed_month,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_text_byte,
   input  logic             req_end_of_text,
   output logic             push,
   output tte_pkg::rec_type push_rec,
   input  logic             queue_full
);
   import tte_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [4:0]  pos_ff, pos_in;
   logic        err_ff, err_in;
   logic [13:0] year_ff, year_in;
   logic [3:0]  mon_ff, mon_in;
   logic [6:0]  day_ff, day_in;
   logic [16:0] hms_ff, hms_in;
   logic [19:0] frac_ff, frac_in;
   logic [2:0]  fdig_ff, fdig_in;
   logic [15:0] let_ff, let_in;
   logic [3:0]  pair_ff, pair_in;

   logic        accept, dig;
   logic [3:0]  d;
   logic [7:0]  b;
   logic [3:0]  mfound;
   logic [6:0]  mval, pval;
   logic [2:0]  tt;
   logic        dec, ok;
   logic [14:0] yv;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign b         = req_text_byte;
   assign dig       = (b >= "0") && (b <= "9");
   assign d         = dig ? b[3:0] : 4'd0;
   assign mfound    = month_of(let_ff[15:8], let_ff[7:0], b);
   assign mval      = 7'({3'd0, mon_ff} * 7'd10) + {3'd0, d};
   assign pval      = 7'({3'd0, pair_ff} * 7'd10) + {3'd0, d};
   assign tt        = 3'(4'(phase_ff) - 4'(PH_TIME0));

   always_comb begin
      phase_in = phase_ff;
      err_in   = err_ff;
      year_in  = year_ff;
      mon_in   = mon_ff;
      day_in   = day_ff;
      hms_in   = hms_ff;
      frac_in  = frac_ff;
      fdig_in  = fdig_ff;
      let_in   = let_ff;
      pair_in  = pair_ff;
      pos_in   = (pos_ff == 5'd31) ? pos_ff : pos_ff + 5'd1;
      if (!err_ff) begin
         case (phase_ff)
            PH_DATE: begin
               if (format_mode == MODE_SYSLOG) begin
                  if (pos_ff == 5'd0) let_in = {b, 8'h00};
                  else if (pos_ff == 5'd1) let_in = {let_ff[15:8], b};
                  else if (pos_ff == 5'd2) begin
                     if (mfound == 4'd0) err_in = 1'b1;
                     else mon_in = mfound;
                  end else if (pos_ff == 5'd3 && b == " ") phase_in = PH_SYS_PAD;
                  else err_in = 1'b1;
               end else if (format_mode == MODE_BAD) begin
                  err_in = 1'b1;
               end else if (pos_ff <= 5'd3 && dig) begin
                  year_in = 14'(year_ff * 14'd10) + {10'd0, d};
               end else if ((pos_ff == 5'd4 || pos_ff == 5'd7) && b == "-") begin
                  err_in = 1'b0;
               end else if (pos_ff == 5'd5 && dig) begin
                  mon_in = d;
               end else if (pos_ff == 5'd6 && dig) begin
                  if (mval < 7'd1 || mval > 7'd12) err_in = 1'b1;
                  else mon_in = mval[3:0];
               end else if (pos_ff == 5'd8 && dig) begin
                  day_in = {3'd0, d};
               end else if (pos_ff == 5'd9 && dig) begin
                  day_in = 7'(day_ff * 7'd10) + {3'd0, d};
               end else if (pos_ff == 5'd10 &&
                            b == ((format_mode == MODE_ISO_T) ? "T" : " ")) begin
                  phase_in = PH_TIME0;
               end else begin
                  err_in = 1'b1;
               end
            end
            PH_SYS_PAD: begin
               if (b == " ") phase_in = PH_SYS_FIRST;
               else if (dig) begin
                  day_in   = {3'd0, d};
                  phase_in = PH_SYS_DAY1;
               end else err_in = 1'b1;
            end
            PH_SYS_FIRST: begin
               if (dig) begin
                  day_in   = {3'd0, d};
                  phase_in = PH_SYS_DAY1;
               end else err_in = 1'b1;
            end
            PH_SYS_DAY1: begin
               if (dig) begin
                  day_in   = 7'(day_ff * 7'd10) + {3'd0, d};
                  phase_in = PH_SYS_DAY2;
               end else if (b == " ") phase_in = PH_TIME0;
               else err_in = 1'b1;
            end
            PH_SYS_DAY2: begin
               if (b == " ") phase_in = PH_TIME0;
               else err_in = 1'b1;
            end
            PH_AFTER_SEC: begin
               if (format_mode < MODE_SYSLOG && (b == "." || b == ",")) begin
                  phase_in = PH_FRACTION;
                  fdig_in  = 3'd0;
                  frac_in  = 20'd0;
               end else if (format_mode < MODE_SYSLOG && b == "Z") phase_in = PH_AFTER_Z;
               else err_in = 1'b1;
            end
            PH_FRACTION: begin
               if (dig && fdig_ff < 3'd6) begin
                  frac_in = 20'(frac_ff * 20'd10) + {16'd0, d};
                  fdig_in = fdig_ff + 3'd1;
               end else if (b == "Z" && fdig_ff >= 3'd1) phase_in = PH_AFTER_Z;
               else err_in = 1'b1;
            end
            PH_AFTER_Z: err_in = 1'b1;
            default: begin
               // the eight bytes of HH:MM:SS
               if (tt == 3'd2 || tt == 3'd5) begin
                  if (b != ":") err_in = 1'b1;
               end else if (!dig) begin
                  err_in = 1'b1;
               end else if (tt == 3'd0 || tt == 3'd3 || tt == 3'd6) begin
                  pair_in = d;
               end else if (tt == 3'd1) begin
                  if (pval > 7'd23) err_in = 1'b1;
                  else hms_in = hms_ff + 17'(pval * 17'd3600);
               end else if (tt == 3'd4) begin
                  if (pval > 7'd59) err_in = 1'b1;
                  else hms_in = hms_ff + 17'(pval * 17'd60);
               end else begin
                  if (pval > 7'd60) err_in = 1'b1;
                  else hms_in = hms_ff + {10'd0, pval};
               end
               if (!err_in) begin
                  phase_in = (tt == 3'd7) ? PH_AFTER_SEC : phase_type'(4'(phase_ff) + 4'd1);
               end
            end
         endcase
      end
   end

   // End-of-text checks on the updated state.
   always_comb begin
      dec = mon_in > assumed_month;
      ok  = !err_in && format_mode != MODE_BAD;
      if (format_mode < MODE_SYSLOG) begin
         yv = {1'b0, year_in};
         if (!(phase_in == PH_AFTER_SEC || phase_in == PH_AFTER_Z ||
               (phase_in == PH_FRACTION && fdig_in >= 3'd1))) ok = 1'b0;
      end else begin
         yv = {1'b0, assumed_year} - {14'd0, dec};
         if (phase_in != PH_AFTER_SEC || pos_in < 5'd15) ok = 1'b0;
      end
      if (yv[14] || yv > 15'd9999 || mon_in < 4'd1 || mon_in > 4'd12 || day_in < 7'd1) begin
         ok = 1'b0;
      end
      push_rec.ok    = ok;
      push_rec.year  = yv[13:0];
      push_rec.month = mon_in;
      push_rec.day   = day_in;
      push_rec.hms   = hms_in;
      push_rec.frac  = (phase_in == PH_FRACTION || phase_in == PH_AFTER_Z) ? frac_in : 20'd0;
      push_rec.fdig  = fdig_in;
   end

   assign push = accept && req_end_of_text;

   always_ff @(posedge clock) begin
      if (reset || (accept && req_end_of_text)) begin
         phase_ff <= PH_DATE;
         pos_ff   <= 5'd0;
         err_ff   <= 1'b0;
         year_ff  <= 14'd0;
         mon_ff   <= 4'd0;
         day_ff   <= 7'd0;
         hms_ff   <= 17'd0;
         frac_ff  <= 20'd0;
         fdig_ff  <= 3'd0;
         let_ff   <= 16'd0;
         pair_ff  <= 4'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         err_ff   <= err_in;
         year_ff  <= year_in;
         mon_ff   <= mon_in;
         day_ff   <= day_in;
         hms_ff   <= hms_in;
         frac_ff  <= frac_in;
         fdig_ff  <= fdig_in;
         let_ff   <= let_in;
         pair_ff  <= pair_in;
      end
   end

endmodule

[hdl/tte_queue.sv]
// Short record queue between the byte parser and the epoch converter.
module tte_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tte_pkg::rec_type push_rec,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output tte_pkg::rec_type pop_rec
);
   import tte_pkg::*;

   localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   rec_type          mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wp_ff, wp_in, rp_ff, rp_in;
   logic [PW:0]      cnt_ff, cnt_in;

   assign full      = cnt_ff == (PW+1)'(QUEUE_DEPTH);
   assign not_empty = cnt_ff != '0;
   assign pop_rec   = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in = (wp_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      end
      if (pop) begin
         rp_in = (rp_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_ff + 1'b1;
      end
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_rec;
   end

endmodule

[hdl/tte_back.sv]
// Epoch converter: turns one parsed record into microseconds over ten steps.
module tte_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                not_empty,
   input  tte_pkg::rec_type    pop_rec,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_parse_ok,
   output logic signed [58:0]  rsp_epoch_micros
);
   import tte_pkg::*;

   localparam logic [3:0] LAST_STEP = 4'd9;

   back_state_type     state_ff, state_in;
   logic [3:0]         step_ff;
   rec_type            rec_ff;
   logic [13:0]        yp_ff;
   logic               neg_ff, leap_ff, date_ok_ff;
   logic [26:0]        prod_ff;
   logic signed [5:0]  era_ff;
   logic [8:0]         yoe_ff;
   logic [17:0]        doe_ff;
   logic signed [22:0] days_ff;
   logic signed [39:0] sec_ff;
   logic signed [40:0] hi_ff;
   logic [39:0]        lo_ff;
   logic [19:0]        fs_ff;
   logic               ok_ff;
   logic signed [58:0] micros_ff;

   logic [7:0]         q100;
   logic [13:0]        r100;
   logic [13:0]        yoe_full;
   logic [14:0]        yoe_q;

   assign pop              = (state_ff == BK_IDLE) && not_empty;
   assign rsp_valid        = state_ff == BK_DONE;
   assign rsp_parse_ok     = ok_ff;
   assign rsp_epoch_micros = micros_ff;

   assign q100     = prod_ff[26:19];
   assign r100     = rec_ff.year - 14'(q100 * 14'd100);
   assign yoe_full = yp_ff - 14'({8'd0, q100[7:2]} * 14'd400);
   assign yoe_q    = 15'(yoe_ff * 15'd41);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: if (not_empty) state_in = BK_RUN;
         BK_RUN:  if (step_ff == LAST_STEP) state_in = BK_DONE;
         BK_DONE: if (!rsp_stall) state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         step_ff  <= 4'd0;
      end else begin
         state_ff <= state_in;
         if (state_ff == BK_RUN) step_ff <= (step_ff == LAST_STEP) ? 4'd0 : step_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) rec_ff <= pop_rec;
      if (state_ff == BK_RUN) begin
         case (step_ff)
            4'd0: begin
               // shift to a March-based year; year zero in Jan/Feb falls into era -1
               yp_ff   <= rec_ff.year - {13'd0, rec_ff.month <= 4'd2};
               neg_ff  <= (rec_ff.year == 14'd0) && (rec_ff.month <= 4'd2);
               prod_ff <= rec_ff.year * 13'd5243;
            end
            4'd1: begin
               leap_ff <= (rec_ff.year[1:0] == 2'd0) && (r100 != 14'd0 || q100[1:0] == 2'd0);
               prod_ff <= yp_ff * 13'd5243;
            end
            4'd2: begin
               era_ff     <= neg_ff ? -6'sd1 : $signed({1'b0, q100[6:2]});
               yoe_ff     <= neg_ff ? 9'd399 : yoe_full[8:0];
               date_ok_ff <= {2'd0, rec_ff.day} <= ({2'd0, month_days(rec_ff.month)} +
                                                    {6'd0, rec_ff.month == 4'd2 && leap_ff});
            end
            4'd3: begin
               doe_ff <= 18'(yoe_ff * 18'd365) + {11'd0, yoe_ff[8:2]} - {15'd0, yoe_q[14:12]}
                         + {9'd0, doy_base(rec_ff.month)} + {11'd0, rec_ff.day} - 18'd1;
            end
            4'd4: begin
               days_ff <= 23'({{17{era_ff[5]}}, era_ff} * 23'sd146097)
                          + $signed({5'd0, doe_ff}) - 23'sd719468;
            end
            4'd5: begin
               sec_ff <= 40'({{17{days_ff[22]}}, days_ff} * 40'sd86400)
                         + $signed({23'd0, rec_ff.hms});
            end
            4'd6: hi_ff <= $signed({{21{sec_ff[39]}}, sec_ff[39:20]}) * 41'sd1000000;
            4'd7: lo_ff <= {20'd0, sec_ff[19:0]} * 40'd1000000;
            4'd8: fs_ff <= 20'(rec_ff.frac * {3'd0, frac_scale(rec_ff.fdig)});
            4'd9: begin
               ok_ff     <= rec_ff.ok && date_ok_ff;
               micros_ff <= (rec_ff.ok && date_ok_ff) ?
                            $signed({hi_ff[38:0], 20'd0} + 59'(lo_ff) + 59'(fs_ff)) : 59'sd0;
            end
            default: ok_ff <= 1'b0;
         endcase
      end
   end

endmodule

[hdl/timestamp_text_to_epoch.sv]
// Top level of the timestamp text to epoch microseconds parser.
//
// Input channel (req_): one text byte per word, req_end_of_text marks the last
// byte of a timestamp. Bytes are taken one per cycle; req_stall rises only when
// the record queue between parser and converter is full.
// Result channel (rsp_): one word per timestamp, parse_ok and the signed
// microseconds since 1970-01-01 UTC (zero on a failed parse).
// A finished record passes through the queue into the converter, whose date
// arithmetic runs as ten steps; the converter works on one timestamp at a time
// and holds its result while rsp_stall is high before taking the next record.
// A stalled result holds on rsp_ until taken; the parser keeps taking bytes
// while the queue (two records) has room.
// Reset (synchronous, active high) returns the parser to the start of text,
// empties the queue, drops any pending result and sets the registers to ISO
// with T, year 1970, month 1. Write csr_ only while the block is idle.
module timestamp_text_to_epoch (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [13:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_text_byte,
   input  logic               req_end_of_text,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_parse_ok,
   output logic signed [58:0] rsp_epoch_micros
);
   import tte_pkg::*;

   logic [1:0]  mode_ff;
   logic [13:0] year_ff;
   logic [3:0]  month_ff;

   logic    push, full, pop, not_empty;
   rec_type push_rec, pop_rec;

   // configuration registers; writes to unused indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_ISO_T;
         year_ff  <= 14'd1970;
         month_ff <= 4'd1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FORMAT_MODE:   mode_ff  <= csr_wdata[1:0];
            CSR_ASSUMED_YEAR:  year_ff  <= csr_wdata;
            CSR_ASSUMED_MONTH: month_ff <= csr_wdata[3:0];
            default:           mode_ff  <= mode_ff;
         endcase
      end
   end

   // front: byte parser, one byte per cycle while the queue is not full
   tte_front u_front (
      .clock           (clock),
      .reset           (reset),
      .format_mode     (mode_ff),
      .assumed_year    (year_ff),
      .assumed_month   (month_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .push            (push),
      .push_rec        (push_rec),
      .queue_full      (full)
   );

   // hold finished records until the converter is free
   tte_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_rec  (push_rec),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_rec   (pop_rec)
   );

   // back: calendar and microsecond arithmetic
   tte_back u_back (
      .clock            (clock),
      .reset            (reset),
      .not_empty        (not_empty),
      .pop_rec          (pop_rec),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_parse_ok     (rsp_parse_ok),
      .rsp_epoch_micros (rsp_epoch_micros)
   );

endmodule

[sim/timestamp_text_to_epoch_tb.sv]
// Self-checking testbench of the timestamp text to epoch microseconds parser.
module timestamp_text_to_epoch_tb;
   import tte_pkg::*;

   // One directed text; typed expectations are used where has_known is set.
   typedef struct {
      logic [1:0] mode;
      string      txt;
      bit         has_known;
      bit         known_ok;
      longint     known_us;
   } text_row_type;

   typedef struct {
      bit                 ok;
      logic signed [58:0] us;
   } stamp_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_we = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [13:0]        csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_text_byte = '0;
   logic               req_end_of_text = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_parse_ok;
   logic signed [58:0] rsp_epoch_micros;

   timestamp_text_to_epoch u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_text_byte    (req_text_byte),
      .req_end_of_text  (req_end_of_text),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_parse_ok     (rsp_parse_ok),
      .rsp_epoch_micros (rsp_epoch_micros)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Register copies kept by the predictor.
   logic [1:0]  cfg_mode = MODE_ISO_T;
   int          cfg_year = 1970;
   int          cfg_month = 1;

   // Parser state of the predictor.
   int          pos;
   phase_type   ph;
   bit          err;
   int          yr_acc, mo_acc, dy_acc, sec_acc, fr_acc, fr_dig, pair_hi;
   logic [15:0] letters;

   int          idle_pct = 0;
   int          stall_pct = 0;
   int          mismatches = 0;
   int          bytes_sent = 0;
   int          stamps_seen = 0;
   bit          use_known = 0;
   bit          known_ok;
   longint      known_us;
   stamp_type   pending_stamps[$];
   logic [7:0]  txt_q[$];

   // Values sampled mid-cycle so that edge decisions never race the block.
   logic               req_stall_s = 1'b0;
   logic               rsp_valid_s = 1'b0;
   logic               rsp_ok_s;
   logic signed [58:0] rsp_us_s;

   string month_abbr = "JanFebMarAprMayJunJulAugSepOctNovDec";
   int    month_len[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   function automatic void clear_parse();
      pos = 0; ph = PH_DATE; err = 0;
      yr_acc = 0; mo_acc = 0; dy_acc = 0; sec_acc = 0;
      fr_acc = 0; fr_dig = 0; pair_hi = 0; letters = '0;
   endfunction

   function automatic bit leap_year(longint y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic longint days_since_1970(longint y, longint m, longint d);
      longint era, yoe, doy, doe;
      if (m <= 2) y -= 1;
      era = (y >= 0 ? y : y - 399) / 400;
      yoe = y - era * 400;
      doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + d - 1;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      return era * 146097 + doe - 719468;
   endfunction

   // Advance the parser copy by one text byte.
   function automatic void parse_byte(logic [7:0] b);
      bit dig;
      int d, t, v, lim, w, found;
      dig = (b >= "0" && b <= "9");
      d = dig ? int'(b) - 48 : 0;
      if (!err) begin
         case (ph)
            PH_DATE: begin
               if (cfg_mode == MODE_SYSLOG) begin
                  if (pos == 0) letters = {b, 8'h00};
                  else if (pos == 1) letters[7:0] = b;
                  else if (pos == 2) begin
                     found = 0;
                     for (int i = 0; i < 12; i++)
                        if (found == 0 && month_abbr[3*i] == letters[15:8] &&
                            month_abbr[3*i+1] == letters[7:0] && month_abbr[3*i+2] == b)
                           found = i + 1;
                     if (found == 0) err = 1; else mo_acc = found;
                  end else if (pos == 3 && b == " ") ph = PH_SYS_PAD;
                  else err = 1;
               end else if (cfg_mode == MODE_BAD) err = 1;
               else if (pos <= 3 && dig) yr_acc = yr_acc * 10 + d;
               else if ((pos == 4 || pos == 7) && b == "-") ;
               else if (pos == 5 && dig) mo_acc = d;
               else if (pos == 6 && dig) begin
                  v = mo_acc * 10 + d;
                  if (v < 1 || v > 12) err = 1; else mo_acc = v;
               end else if (pos == 8 && dig) dy_acc = d;
               else if (pos == 9 && dig) dy_acc = dy_acc * 10 + d;
               else if (pos == 10 && b == (cfg_mode == MODE_ISO_T ? "T" : " ")) ph = PH_TIME0;
               else err = 1;
            end
            PH_SYS_PAD: begin
               if (b == " ") ph = PH_SYS_FIRST;
               else if (dig) begin
                  dy_acc = d; ph = PH_SYS_DAY1;
               end else err = 1;
            end
            PH_SYS_FIRST: begin
               if (dig) begin
                  dy_acc = d; ph = PH_SYS_DAY1;
               end else err = 1;
            end
            PH_SYS_DAY1: begin
               if (dig) begin
                  dy_acc = dy_acc * 10 + d; ph = PH_SYS_DAY2;
               end else if (b == " ") ph = PH_TIME0;
               else err = 1;
            end
            PH_SYS_DAY2: begin
               if (b == " ") ph = PH_TIME0; else err = 1;
            end
            PH_AFTER_SEC: begin
               if (cfg_mode < MODE_SYSLOG && (b == "." || b == ",")) begin
                  ph = PH_FRACTION; fr_dig = 0; fr_acc = 0;
               end else if (cfg_mode < MODE_SYSLOG && b == "Z") ph = PH_AFTER_Z;
               else err = 1;
            end
            PH_FRACTION: begin
               if (dig && fr_dig < 6) begin
                  fr_acc = fr_acc * 10 + d; fr_dig++;
               end else if (b == "Z" && fr_dig >= 1) ph = PH_AFTER_Z;
               else err = 1;
            end
            PH_AFTER_Z: err = 1;
            default: begin
               // HH:MM:SS, one byte per phase
               t = int'(ph) - int'(PH_TIME0);
               if (t == 2 || t == 5) begin
                  if (b != ":") err = 1;
               end else if (!dig) err = 1;
               else if (t == 0 || t == 3 || t == 6) pair_hi = d;
               else begin
                  v = pair_hi * 10 + d;
                  lim = (t == 1) ? 23 : (t == 4) ? 59 : 60;
                  w = (t == 1) ? 3600 : (t == 4) ? 60 : 1;
                  if (v > lim) err = 1; else sec_acc += v * w;
               end
               if (!err) ph = (t == 7) ? PH_AFTER_SEC : phase_type'(ph + 1);
            end
         endcase
      end
      if (pos < 31) pos++;
   endfunction

   // Judge the finished text and return the parser copy to the start of text.
   function automatic stamp_type close_text();
      stamp_type r;
      bit        good;
      longint    y, f;
      r.ok = 0; r.us = '0;
      good = !err && cfg_mode != MODE_BAD;
      y = 0;
      if (good && cfg_mode < MODE_SYSLOG) begin
         good = ph == PH_AFTER_SEC || ph == PH_AFTER_Z || (ph == PH_FRACTION && fr_dig >= 1);
         y = yr_acc;
      end else if (good) begin
         good = ph == PH_AFTER_SEC && pos >= 15;
         y = longint'(cfg_year) - (mo_acc > cfg_month ? 1 : 0);
      end
      if (good && (y < 0 || y > 9999 || mo_acc < 1 || mo_acc > 12 || dy_acc < 1)) good = 0;
      if (good && dy_acc > month_len[mo_acc-1] + ((mo_acc == 2 && leap_year(y)) ? 1 : 0))
         good = 0;
      if (good) begin
         f = fr_acc;
         for (int k = fr_dig; k < 6; k++) f *= 10;
         if (ph == PH_AFTER_SEC) f = 0;
         r.ok = 1;
         r.us = days_since_1970(y, mo_acc, dy_acc) * 64'sd86400000000 +
                longint'(sec_acc) * 1000000 + f;
      end
      clear_parse();
      return r;
   endfunction

   initial clear_parse();

   always @(negedge clock) begin
      req_stall_s <= req_stall;
      rsp_valid_s <= rsp_valid;
      rsp_ok_s    <= rsp_parse_ok;
      rsp_us_s    <= rsp_epoch_micros;
   end

   // Input monitor: predict on every accepted word.
   always @(posedge clock) begin
      stamp_type s;
      if (!reset && req_valid && !req_stall_s) begin
         parse_byte(req_text_byte);
         if (req_end_of_text) begin
            s = close_text();
            if (use_known) begin
               s.ok = known_ok;
               s.us = known_us;
            end
            pending_stamps.insert(pending_stamps.size(), s);
         end
      end
   end

   // Result side: random stall, compare each taken word with the oldest expectation.
   always @(posedge clock) begin
      stamp_type s;
      if (!reset && rsp_valid_s && !rsp_stall) begin
         stamps_seen++;
         if (pending_stamps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: ok=%0d us=%0d", rsp_ok_s, rsp_us_s);
         end else begin
            s = pending_stamps.pop_front();
            if (s.ok !== rsp_ok_s || s.us !== rsp_us_s) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected ok=%0d us=%0d, got ok=%0d us=%0d",
                           s.ok, s.us, rsp_ok_s, rsp_us_s);
            end
         end
      end
      rsp_stall <= !reset && stall_pct != 0 && $urandom_range(99) < stall_pct;
   end

   // Drive one word and hold it until taken.
   task automatic send_word(logic [7:0] b, logic last);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_text_byte   <= b;
      req_end_of_text <= last;
      do @(posedge clock); while (req_stall_s);
      bytes_sent++;
   endtask

   task automatic send_text();
      foreach (txt_q[i]) send_word(txt_q[i], i == txt_q.size() - 1);
   endtask

   // Drop valid and let the block drain before touching the registers.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_stamps.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_regs(logic [1:0] mode, int year, int month);
      @(posedge clock);
      csr_we <= 1'b1; csr_index <= CSR_FORMAT_MODE; csr_wdata <= 14'(mode);
      @(posedge clock);
      csr_index <= CSR_ASSUMED_YEAR; csr_wdata <= 14'(year);
      @(posedge clock);
      csr_index <= CSR_ASSUMED_MONTH; csr_wdata <= 14'(month);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_mode = mode; cfg_year = year; cfg_month = month;
   endtask

   // Append one byte to the text under construction.
   function automatic void add_char(logic [7:0] c);
      txt_q.insert(txt_q.size(), c);
   endfunction

   function automatic void push_digits(int v, int n);
      int div;
      div = 1;
      for (int i = 1; i < n; i++) div *= 10;
      for (int i = 0; i < n; i++) begin
         add_char(8'(48 + (v / div) % 10));
         div /= 10;
      end
   endfunction

   function automatic void push_clock();
      bit wide;
      wide = $urandom_range(9) == 0;
      push_digits(wide ? $urandom_range(29) : $urandom_range(23), 2);
      add_char(":");
      push_digits(wide ? $urandom_range(69) : $urandom_range(59), 2);
      add_char(":");
      push_digits(wide ? $urandom_range(69) : $urandom_range(60), 2);
   endfunction

   // Build one random text: mostly well formed for the current mode, some noise.
   function automatic void make_text();
      int  kind, n, c, cut;
      bit  sys;
      txt_q.delete();
      kind = $urandom_range(99);
      sys = (cfg_mode == MODE_SYSLOG) ? (kind >= 20) : (kind < 20);
      if (kind < 8) begin
         n = $urandom_range(1, 40);
         repeat (n) add_char(8'($urandom_range(255)));
      end else if (!sys) begin
         push_digits($urandom_range(9999), 4);
         add_char("-");
         push_digits($urandom_range(9) == 0 ? $urandom_range(19) : $urandom_range(1, 12), 2);
         add_char("-");
         push_digits($urandom_range(9) == 0 ? $urandom_range(39) : $urandom_range(1, 31), 2);
         if ($urandom_range(11) == 0) add_char($urandom_range(1) ? "t" : "T");
         else add_char(cfg_mode == MODE_ISO_SPACE ? " " : "T");
         push_clock();
         if ($urandom_range(2) != 0) begin
            add_char($urandom_range(1) ? "." : ",");
            n = $urandom_range(7) == 0 ? 7 * $urandom_range(1) : $urandom_range(1, 6);
            repeat (n) push_digits($urandom_range(9), 1);
         end
         if ($urandom_range(1)) add_char("Z");
      end else begin
         n = $urandom_range(11);
         if ($urandom_range(9) == 0) begin
            repeat (3) add_char(8'($urandom_range(65, 122)));
         end else begin
            for (int i = 0; i < 3; i++) add_char(month_abbr[3*n+i]);
         end
         add_char(" ");
         n = $urandom_range(9) == 0 ? $urandom_range(39) : $urandom_range(1, 31);
         if (n < 10) begin
            if ($urandom_range(1)) add_char(" ");
            push_digits(n, 1);
         end else push_digits(n, 2);
         add_char(" ");
         push_clock();
         if ($urandom_range(19) == 0) add_char("Z");
      end
      c = $urandom_range(99);
      if (c < 6) txt_q[$urandom_range(txt_q.size() - 1)] = 8'($urandom_range(255));
      else if (c < 12) begin
         cut = $urandom_range(1, txt_q.size());
         while (txt_q.size() > cut) void'(txt_q.pop_back());
      end else if (c < 16) repeat ($urandom_range(1, 15)) add_char(8'($urandom_range(255)));
   endfunction

   text_row_type dir_rows[24];

   initial begin
      int settings[9][5];
      int phase_bytes;
      logic [1:0] m;
      dir_rows = '{
         '{MODE_ISO_T, "1970-01-01T00:00:00", 1, 1, 0},
         '{MODE_ISO_T, "0000-01-01T00:00:00Z", 1, 1, -64'sd62167219200000000},
         '{MODE_ISO_T, "9999-12-31T23:59:60.999999Z", 1, 1, 64'sd253402300800999999},
         '{MODE_ISO_T, "2000-02-29T12:34:56.5", 0, 0, 0},
         '{MODE_ISO_T, "1900-02-29T00:00:00", 1, 0, 0},
         '{MODE_ISO_T, "2024-13-01T00:00:00", 1, 0, 0},
         '{MODE_ISO_T, "2024-01-01T24:00:00", 1, 0, 0},
         '{MODE_ISO_T, "2024-01-01T00:60:00", 1, 0, 0},
         '{MODE_ISO_T, "2024-01-01T00:00:61", 1, 0, 0},
         '{MODE_ISO_T, "2024-01-01T00:00:00.", 1, 0, 0},
         '{MODE_ISO_T, "2024-01-01T00:00:00.1234567", 1, 0, 0},
         '{MODE_ISO_T, "2024-01-01T00:00:00Zx", 1, 0, 0},
         '{MODE_ISO_T, "2024-01-01T00:00", 1, 0, 0},
         '{MODE_ISO_T, "2024-04-31T00:00:00", 1, 0, 0},
         '{MODE_ISO_T, "2024-01-00T00:00:00", 1, 0, 0},
         '{MODE_ISO_T, "2024-06-15 08:00:00,25Z", 1, 0, 0},
         '{MODE_ISO_SPACE, "2024-06-15 08:00:00,25Z", 0, 0, 0},
         '{MODE_SYSLOG, "Feb 29 23:59:60", 1, 0, 0},
         '{MODE_SYSLOG, "Jan  1 00:00:00", 1, 1, 0},
         '{MODE_SYSLOG, "Dec 31 23:59:59", 0, 0, 0},
         '{MODE_SYSLOG, "Jan 1 00:00:00", 1, 0, 0},
         '{MODE_SYSLOG, "Foo 10 10:10:10", 1, 0, 0},
         '{MODE_SYSLOG, "Mar 10 10:10:10Z", 1, 0, 0},
         '{MODE_BAD, "1970-01-01T00:00:00", 1, 0, 0}
      };
      // mode, assumed year, assumed month, sender idle %, receiver stall %
      settings = '{
         '{0, 1970, 1, 0, 0},   '{1, 1, 12, 56, 0},    '{2, 9999, 12, 0, 56},
         '{2, 1, 1, 38, 38},    '{2, 0, 15, 0, 0},     '{2, 16383, 0, 56, 0},
         '{3, 2024, 6, 0, 56},  '{0, 2024, 6, 38, 38}, '{2, 2024, 2, 0, 0}
      };

      // hold reset at start-up, then release once
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed texts; switch mode only after the block has drained
      foreach (dir_rows[r]) begin
         if (dir_rows[r].mode != cfg_mode) begin
            wait_idle();
            write_regs(dir_rows[r].mode, cfg_year, cfg_month);
         end
         // update at the end of the step so the monitor still sees the previous text's values
         use_known <= dir_rows[r].has_known;
         known_ok  <= dir_rows[r].known_ok;
         known_us  <= dir_rows[r].known_us;
         txt_q.delete();
         for (int i = 0; i < dir_rows[r].txt.len(); i++) add_char(dir_rows[r].txt[i]);
         send_text();
      end
      use_known <= 0;

      // random texts under each register setting and idle pattern
      foreach (settings[p]) begin
         wait_idle();
         m = 2'(settings[p][0]);
         write_regs(m, settings[p][1], settings[p][2]);
         idle_pct  = settings[p][3];
         stall_pct = settings[p][4];
         phase_bytes = bytes_sent;
         while (bytes_sent - phase_bytes < 35) begin
            make_text();
            send_text();
         end
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_stamps.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Drop the run if it hangs.
   initial begin
      #(20 * 2000000);
      $display("CHECK FAILED");
      $finish;
   end

endmodule

[files.f]
hdl/tte_pkg.sv
hdl/tte_front.sv
hdl/tte_queue.sv
hdl/tte_back.sv
hdl/timestamp_text_to_epoch.sv
sim/timestamp_text_to_epoch_tb.sv
